@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the chunked body decoder RTL, used by cbd_core.
// No dependencies; every macro collapses to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check a property on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ hw/rtl/cbd_pkg.sv @@
// Shared types and constants of the chunked body decoder.
// No dependencies; imported by every decoder module.
package cbd_pkg;

  // Reset value of the body length limit
  localparam logic [31:0] MAX_BODY_RESET = 32'd1048576;

  // Decoder status codes
  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_BAD_SIZE  = 3'd3,
    ST_TOO_LARGE = 3'd4
  } cbd_status_t;

  // One encoded byte of the body
  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } cbd_in_t;

  // One decoder result
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       end_of_message;
  } cbd_out_t;

  // Handshake between the input register and the result register
  typedef struct packed {
    logic fire;
    logic take;
  } cbd_hs_t;

endpackage

@@ hw/rtl/cbd_in_stage.sv @@
// Input register of the chunked body decoder.
// Depends on cbd_pkg for the item and handshake types.
module cbd_in_stage
  import cbd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    byte_valid,
  output logic    byte_stall,
  input  cbd_in_t byte_item,
  input  logic    take,
  output logic    fire,
  output cbd_in_t held_item
);

  logic held_valid;

  // Move the held item on whenever the result register can take it
  assign fire       = held_valid & take;
  assign byte_stall = held_valid & ~take;

  // Load a new item whenever the register is free or empties this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      held_item <= byte_item;
    end
  end

endmodule

@@ hw/rtl/cbd_core.sv @@
// Decode state and per-byte step logic of the chunked body decoder.
// Depends on cbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbd_core
  import cbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cbd_hs_t     hs,
  input  cbd_in_t     item,
  input  logic [31:0] max_body_bytes,
  output cbd_out_t    result
);

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_DIGITS = 3'd1,
    PH_TRAIL  = 3'd2,
    PH_EXT    = 3'd3,
    PH_DATA   = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // Decode a hex digit: bit 4 flags a digit, bits 3:0 give its value
  function automatic logic [4:0] hex_decode(input logic [7:0] ch);
    logic [4:0] r;
    r = 5'd0;
    if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, ch[3:0]};
    end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
      r = {1'b1, ch[3:0] + 4'd9};
    end
    return r;
  endfunction

  phase_t      phase, phase_next;
  logic        cr_pending, cr_pending_next;
  logic        line_bad, line_bad_next;
  logic        saw_digit, saw_digit_next;
  logic [63:0] chunk_size, chunk_size_next;
  logic [31:0] body_count, body_count_next;
  logic [1:0]  skip_left, skip_left_next;
  cbd_status_t final_status, final_status_next;

  logic [7:0]  c;
  logic [4:0]  hx;
  logic        is_blank;
  logic        is_cr;
  logic        digit_ovf;
  logic [32:0] limit_sum;
  logic        too_large;
  logic [31:0] data_left;
  logic [1:0]  skip_dec;
  logic        res_valid;
  logic [7:0]  res_byte;
  cbd_status_t res_status;

  assign c         = item.in_byte;
  assign hx        = hex_decode(c);
  assign is_blank  = (c == CH_SP) || (c == CH_TAB);
  assign is_cr     = (c == CH_CR);
  assign digit_ovf = (chunk_size[63:60] != 4'd0);
  assign data_left = chunk_size[31:0] - 32'd1;
  assign skip_dec  = (skip_left != 2'd0) ? skip_left - 2'd1 : skip_left;

  // Exact limit test: body so far plus the chunk must stay within the limit
  assign limit_sum = {1'b0, body_count} + {1'b0, chunk_size[31:0]};
  assign too_large = (chunk_size[63:32] != 32'd0) || (limit_sum > {1'b0, max_body_bytes});

  // Step the decoder by one byte
  always_comb begin
    phase_next        = phase;
    cr_pending_next   = cr_pending;
    line_bad_next     = line_bad;
    saw_digit_next    = saw_digit;
    chunk_size_next   = chunk_size;
    body_count_next   = body_count;
    skip_left_next    = skip_left;
    final_status_next = final_status;
    res_valid         = 1'b0;
    res_byte          = 8'h00;

    if (final_status == ST_RUNNING) begin
      unique case (phase)
        PH_DATA: begin
          // pass the byte on and count it
          res_valid       = 1'b1;
          res_byte        = c;
          chunk_size_next = {32'd0, data_left};
          body_count_next = body_count + 32'd1;
          if (data_left == 32'd0) begin
            phase_next     = PH_SKIP;
            skip_left_next = 2'd2;
          end
        end
        PH_SKIP: begin
          // drop the two bytes after the data, then open a new size line
          skip_left_next = skip_dec;
          if (skip_dec == 2'd0) begin
            phase_next      = PH_LEAD;
            cr_pending_next = 1'b0;
            line_bad_next   = 1'b0;
            saw_digit_next  = 1'b0;
            chunk_size_next = 64'd0;
          end
        end
        default: begin
          if (c == CH_LF && cr_pending) begin
            // end of size line: judge it
            cr_pending_next = 1'b0;
            priority if (line_bad || !saw_digit) begin
              final_status_next = ST_BAD_SIZE;
            end else if (chunk_size == 64'd0) begin
              final_status_next = ST_COMPLETE;
            end else if (too_large) begin
              final_status_next = ST_TOO_LARGE;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            unique case (phase)
              PH_LEAD: begin
                priority if (is_blank) begin
                end else if (hx[4]) begin
                  if (digit_ovf) begin
                    line_bad_next = 1'b1;
                  end else begin
                    chunk_size_next = {chunk_size[59:0], hx[3:0]};
                  end
                  saw_digit_next = 1'b1;
                  phase_next     = PH_DIGITS;
                end else if (c == CH_SEMI) begin
                  phase_next = PH_EXT;
                end else begin
                  line_bad_next = 1'b1;
                end
              end
              PH_DIGITS: begin
                priority if (hx[4]) begin
                  if (digit_ovf) begin
                    line_bad_next = 1'b1;
                  end else begin
                    chunk_size_next = {chunk_size[59:0], hx[3:0]};
                  end
                  saw_digit_next = 1'b1;
                end else if (is_blank || is_cr) begin
                  phase_next = PH_TRAIL;
                end else if (c == CH_SEMI) begin
                  phase_next = PH_EXT;
                end else begin
                  line_bad_next = 1'b1;
                end
              end
              PH_TRAIL: begin
                priority if (is_blank || is_cr) begin
                end else if (c == CH_SEMI) begin
                  phase_next = PH_EXT;
                end else begin
                  line_bad_next = 1'b1;
                end
              end
              default: begin
                // extension text is ignored up to CRLF
              end
            endcase
            cr_pending_next = is_cr;
          end
        end
      endcase
    end

    // Show the status after this byte; an unfinished body at the end is truncated
    res_status = final_status_next;
    if (item.is_last && final_status_next == ST_RUNNING) begin
      res_status = ST_TRUNCATED;
    end

    // Clear all decode state after the last byte
    if (item.is_last) begin
      phase_next        = PH_LEAD;
      cr_pending_next   = 1'b0;
      line_bad_next     = 1'b0;
      saw_digit_next    = 1'b0;
      chunk_size_next   = 64'd0;
      body_count_next   = 32'd0;
      skip_left_next    = 2'd0;
      final_status_next = ST_RUNNING;
    end
  end

  assign result.out_valid      = res_valid;
  assign result.out_byte       = res_byte;
  assign result.status         = res_status;
  assign result.end_of_message = item.is_last;

  // Hold decode state; advance it when an item passes through
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      cr_pending   <= 1'b0;
      line_bad     <= 1'b0;
      saw_digit    <= 1'b0;
      chunk_size   <= 64'd0;
      body_count   <= 32'd0;
      skip_left    <= 2'd0;
      final_status <= ST_RUNNING;
    end else if (hs.fire) begin
      phase        <= phase_next;
      cr_pending   <= cr_pending_next;
      line_bad     <= line_bad_next;
      saw_digit    <= saw_digit_next;
      chunk_size   <= chunk_size_next;
      body_count   <= body_count_next;
      skip_left    <= skip_left_next;
      final_status <= final_status_next;
    end
  end

  // While data flows, the byte count left is nonzero and fits in 32 bits
  `ASSERT_NEVER(a_data_left_range, clk, rst,
    phase == PH_DATA && (chunk_size[63:32] != 32'd0 || chunk_size[31:0] == 32'd0))
  // Data is only passed while the body is still running
  `ASSERT_PROP(a_data_running, clk, rst,
    (hs.fire && result.out_valid) |-> (final_status == ST_RUNNING))
  // The last byte leaves the decoder cleared
  `ASSERT_PROP(a_clear_after_last, clk, rst,
    (hs.fire && item.is_last) |=>
      (phase == PH_LEAD && body_count == 32'd0 && final_status == ST_RUNNING))
  // The skip counter never exceeds the two bytes after the data
  `ASSERT_NEVER(a_skip_range, clk, rst, skip_left == 2'd3)

endmodule

@@ hw/rtl/cbd_out_stage.sv @@
// Result register of the chunked body decoder.
// Depends on cbd_pkg for the result type.
module cbd_out_stage
  import cbd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  cbd_out_t result,
  output logic     take,
  output logic     res_valid,
  input  logic     res_stall,
  output cbd_out_t res_item
);

  // Free when empty or when the held result leaves this cycle
  assign take = ~res_valid | ~res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire) begin
      res_item <= result;
    end
  end

endmodule

@@ hw/rtl/http_chunked_body_decoder_top.sv @@
// HTTP chunked transfer body decoder, one encoded byte in, one result out.
// Input channel byte_valid/byte_stall/byte_item carries an encoded byte and a
// last-byte flag; output channel res_valid/res_stall/res_item carries one
// result for every byte: a data flag, the decoded byte, the running status
// (running, complete, truncated, bad size, too large) and the end mark.
// cfg_wr_en/cfg_wr_data write the body length limit; write it only while the
// decoder is idle.
// Path: each accepted byte is held in the input register, decoded
// combinationally and registered in the result register, where it can be
// taken. Throughput: one byte per cycle while the output does not stall, set
// by the decode step between the two registers (a digit shift, a 33-bit limit
// add-and-compare and the byte counters).
// A stall on the output holds the result; the input stalls only once both
// registers are full. Reset clears the pipeline and the decode state and
// sets the limit to 1048576 bytes. After the last byte the decode state
// clears on its own; the limit is kept.
// Depends on cbd_pkg, cbd_in_stage, cbd_core and cbd_out_stage.
module http_chunked_body_decoder_top
  import cbd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  cbd_in_t     byte_item,
  output logic        res_valid,
  input  logic        res_stall,
  output cbd_out_t    res_item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0] max_body_bytes;
  cbd_hs_t     hs;
  cbd_in_t     held_item;
  cbd_out_t    result;

  // Hold the body length limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= MAX_BODY_RESET;
    end else if (cfg_wr_en) begin
      max_body_bytes <= cfg_wr_data;
    end
  end

  cbd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .take       (hs.take),
    .fire       (hs.fire),
    .held_item  (held_item)
  );

  cbd_core u_core (
    .clk            (clk),
    .rst            (rst),
    .hs             (hs),
    .item           (held_item),
    .max_body_bytes (max_body_bytes),
    .result         (result)
  );

  cbd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (hs.fire),
    .result    (result),
    .take      (hs.take),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for http_chunked_body_decoder_top: directed framing, size-line
// and limit cases, then random chunked messages under input gaps and output stalls.
// Depends on cbd_pkg and the decoder RTL; holds its own byte-level decode predictor.
module tb;
  import cbd_pkg::*;

  localparam int RUN_LIMIT    = 400000;
  localparam int RANDOM_ITEMS = 800;
  localparam int SHOW_ERRORS  = 10;

  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;

  typedef enum logic [2:0] {
    LINE_LEAD,
    LINE_DIGITS,
    LINE_TRAIL,
    LINE_EXT,
    BODY_DATA,
    BODY_SKIP
  } dec_phase_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        byte_valid  = 1'b0;
  logic        byte_stall;
  cbd_in_t     byte_item   = '0;
  logic        res_valid;
  logic        res_stall   = 1'b0;
  cbd_out_t    res_item;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  // Predictor copy of the limit register and the decode state
  logic [31:0] body_limit;
  dec_phase_t  ph;
  logic        cr_seen;
  logic        line_broken;
  logic        got_digit;
  logic [63:0] size_acc;
  logic [31:0] body_len;
  logic [1:0]  skip_cnt;
  cbd_status_t msg_status;

  cbd_out_t   expected_q[$];
  logic [7:0] msg_q[$];
  int         items_sent = 0;
  int         err_count  = 0;
  int         cycles     = 0;
  int         stall_left = 0;
  bit         idle_on    = 1'b1;

  http_chunked_body_decoder_top uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_item   (byte_item),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res_item    (res_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("http_chunked_body_decoder_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void restart_line();
    ph          = LINE_LEAD;
    cr_seen     = 1'b0;
    line_broken = 1'b0;
    got_digit   = 1'b0;
    size_acc    = '0;
  endfunction

  function automatic void clear_decode();
    restart_line();
    body_len   = '0;
    skip_cnt   = '0;
    msg_status = ST_RUNNING;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  // Shift in one digit; mark the line bad once the value would pass 64 bits
  function automatic void add_digit(int d);
    if (size_acc[63:60] != 4'd0) line_broken = 1'b1;
    else size_acc = {size_acc[59:0], 4'(d)};
    got_digit = 1'b1;
  endfunction

  // CRLF seen: judge the size line and check the body limit without wrap
  function automatic void close_line();
    cr_seen = 1'b0;
    if (line_broken || !got_digit) begin
      msg_status = ST_BAD_SIZE;
    end else if (size_acc == 64'd0) begin
      msg_status = ST_COMPLETE;
    end else if (body_len > body_limit || size_acc > {32'd0, body_limit - body_len}) begin
      msg_status = ST_TOO_LARGE;
    end else begin
      ph = BODY_DATA;
    end
  endfunction

  function automatic void size_line_byte(logic [7:0] c);
    logic blank;
    int   d;
    blank = (c == CH_SP || c == CH_TAB);
    d     = hex_digit(c);
    if (c == CH_LF && cr_seen) begin
      close_line();
      return;
    end
    case (ph)
      LINE_LEAD: begin
        if (!blank) begin
          if (d >= 0) begin
            add_digit(d);
            ph = LINE_DIGITS;
          end else if (c == CH_SEMI) begin
            ph = LINE_EXT;
          end else begin
            line_broken = 1'b1;
          end
        end
      end
      LINE_DIGITS: begin
        if (d >= 0) add_digit(d);
        else if (blank || c == CH_CR) ph = LINE_TRAIL;
        else if (c == CH_SEMI) ph = LINE_EXT;
        else line_broken = 1'b1;
      end
      LINE_TRAIL: begin
        if (c == CH_SEMI) ph = LINE_EXT;
        else if (!(blank || c == CH_CR)) line_broken = 1'b1;
      end
      default: ;
    endcase
    cr_seen = (c == CH_CR);
  endfunction

  // Advance the decode state by one byte and return the result it gives
  function automatic cbd_out_t decode_byte(cbd_in_t it);
    cbd_out_t r;
    r = '0;
    r.end_of_message = it.is_last;
    if (msg_status == ST_RUNNING) begin
      if (ph == BODY_DATA) begin
        r.out_valid = 1'b1;
        r.out_byte  = it.in_byte;
        size_acc    = size_acc - 64'd1;
        body_len    = body_len + 32'd1;
        if (size_acc == 64'd0) begin
          ph       = BODY_SKIP;
          skip_cnt = 2'd2;
        end
      end else if (ph == BODY_SKIP) begin
        if (skip_cnt != 2'd0) skip_cnt = skip_cnt - 2'd1;
        if (skip_cnt == 2'd0) restart_line();
      end else begin
        size_line_byte(it.in_byte);
      end
    end
    r.status = (it.is_last && msg_status == ST_RUNNING) ? ST_TRUNCATED : msg_status;
    if (it.is_last) clear_decode();
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void report_mismatch(string what, cbd_out_t want, cbd_out_t got);
    err_count++;
    if (err_count <= SHOW_ERRORS)
      $display("%0t %s: expected valid=%b byte=%h status=%0d eom=%b, %s",
               $time, what, want.out_valid, want.out_byte, want.status, want.end_of_message,
               $sformatf("got valid=%b byte=%h status=%0d eom=%b",
                         got.out_valid, got.out_byte, got.status, got.end_of_message));
  endfunction

  function automatic void check_result(cbd_out_t got);
    cbd_out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected result", '0, got);
      return;
    end
    want = expected_q.pop_front();
    if (got.out_valid !== want.out_valid || got.out_byte !== want.out_byte ||
        got.status !== want.status || got.end_of_message !== want.end_of_message)
      report_mismatch("result mismatch", want, got);
  endfunction

  // Take results; after each one draw how long to stall the next
  always @(posedge clk) begin : result_side
    int hold;
    hold = 0;
    if (!rst && res_valid && !res_stall) begin
      check_result(res_item);
      if (idle_on) hold = $urandom_range(0, 5);
    end else if (stall_left > 0) begin
      hold = stall_left - 1;
    end
    stall_left <= hold;
    res_stall  <= (hold != 0);
  end

  // ---------------------------------------------------------------- driving

  // Hold valid low for a random gap, then offer one item until it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int      gap;
    cbd_in_t it;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    it.in_byte = b;
    it.is_last = last;
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    expected_q.insert(expected_q.size(), decode_byte(it));
    items_sent++;
  endtask

  task automatic send_queue(input bit mark_last);
    foreach (msg_q[i]) send_byte(msg_q[i], mark_last && i == msg_q.size() - 1);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic settle();
    byte_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [31:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    body_limit = v;
  endtask

  // ---------------------------------------------------------------- message building

  // Append one byte to the message under construction
  function automatic void put_byte(logic [7:0] b);
    msg_q.insert(msg_q.size(), b);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic void load(string s);
    msg_q.delete();
    push_str(s);
  endfunction

  function automatic void push_hex(logic [63:0] v, bit upper);
    int         top;
    logic [3:0] nib;
    top = 0;
    for (int i = 0; i < 16; i++) if (v[i*4 +: 4] != 4'd0) top = i;
    for (int i = top; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) put_byte(8'h30 + 8'(nib));
      else put_byte((upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
    end
  endfunction

  // Well-formed size line with random blanks, leading zeros, case and extension
  function automatic void add_size_line(logic [63:0] v);
    int n;
    n = $urandom_range(0, 2);
    repeat (n) put_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
    repeat (n) put_byte("0");
    push_hex(v, 1'($urandom_range(0, 1)));
    n = $urandom_range(0, 2);
    repeat (n) begin
      case ($urandom_range(0, 2))
        0: put_byte(CH_SP);
        1: put_byte(CH_TAB);
        default: put_byte(CH_CR);
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      put_byte(CH_SEMI);
      n = $urandom_range(0, 4);
      repeat (n) put_byte(8'($urandom_range(8'h21, 8'h7e)));
    end
    put_byte(CH_CR);
    put_byte(CH_LF);
  endfunction

  // Mostly well-formed chunked bodies; some noise, broken size lines and cut-off tails
  function automatic void build_message();
    int kind;
    int nch;
    int sz;
    int n;
    msg_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) put_byte(8'($urandom));
      return;
    end
    nch = $urandom_range(0, 3);
    repeat (nch) begin
      sz = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      add_size_line(64'(sz));
      repeat (sz) put_byte(8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        put_byte(8'($urandom));
        put_byte(8'($urandom));
      end else begin
        put_byte(CH_CR);
        put_byte(CH_LF);
      end
    end
    if (kind == 1) begin
      case ($urandom_range(0, 5))
        0: push_str("\r\n");
        1: push_str("10000000000000000\r\n");
        2: push_str("FFFFFFFFFFFFFFFF\r\n");
        3: push_str("1 2\r\n");
        4: push_str("1\n\r\n");
        default: begin
          push_str("1");
          put_byte(8'($urandom));
          push_str("\r\n");
        end
      endcase
      n = $urandom_range(0, 3);
      repeat (n) put_byte(8'($urandom));
    end else begin
      add_size_line(64'd0);
      if ($urandom_range(0, 1) == 1) push_str("\r\n");
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) put_byte(8'($urandom));
      end
    end
    if (kind == 2 && msg_q.size() > 1) begin
      n = $urandom_range(1, msg_q.size() - 1);
      while (msg_q.size() > n) void'(msg_q.pop_back());
    end
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 6))
      0: return 32'd0;
      1: return 32'd1;
      2, 3: return 32'($urandom_range(2, 40));
      4: return 32'hffff_ffff;
      5: return MAX_BODY_RESET;
      default: return 32'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // Completion, truncation with a data byte, bytes after completion
  task automatic test_frame_ends();
    load("0\r\n");
    send_queue(1'b1);
    load("1\r\n");
    put_byte(8'hff);
    send_queue(1'b1);
    load("0\r\n");
    put_byte(8'h00);
    send_queue(1'b1);
  endtask

  // Empty line, digit after trailing blank, lone LF inside the size
  task automatic test_bad_size_lines();
    load("\r\n");
    send_queue(1'b1);
    load("1 3\r\n");
    send_queue(1'b1);
    load("1\n\r\n");
    send_queue(1'b1);
  endtask

  // Zero limit, exact fit, then limit lowered below the body already passed
  task automatic test_limit_edges();
    cfg_write(32'd0);
    load("1\r\n");
    send_queue(1'b1);
    cfg_write(32'd3);
    load("3\r\nabc\r\n");
    send_queue(1'b0);
    cfg_write(32'd1);
    load("1\r\n");
    send_queue(1'b1);
    cfg_write(32'hffff_ffff);
  endtask

  task automatic test_random_traffic();
    int start;
    int batch;
    start = items_sent;
    batch = 0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (batch == 0) begin
        cfg_write(pick_limit());
        idle_on = ($urandom_range(0, 3) != 0);
        batch   = $urandom_range(4, 10);
      end
      build_message();
      send_queue(1'b1);
      batch--;
    end
  endtask

  initial begin
    body_limit = MAX_BODY_RESET;
    clear_decode();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_frame_ends();
    test_bad_size_lines();
    test_limit_edges();
    test_random_traffic();
    settle();
    if (err_count == 0 && expected_q.size() == 0)
      $display("http_chunked_body_decoder_top regression: pass");
    else
      $display("http_chunked_body_decoder_top regression: fail");
    $finish;
  end

endmodule
